### src/rcsd_pkg.sv
// rcsd_pkg: shared types and constants for the RC channel scale/deadband block.
// Used by every module under src/; no dependencies.
package rcsd_pkg;

  localparam int CH_W       = 4;
  localparam int RAW_W      = 11;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = RAW_W + VAL_W;   // |raw diff| * |out span|
  localparam int DIV_STAGES = PROD_W;          // one quotient bit per stage
  localparam int QUEUE_AW   = 5;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  // register reset values
  localparam logic [RAW_W-1:0] RAW_MIN_RST          = 11'd172;
  localparam logic [RAW_W-1:0] RAW_MAX_RST          = 11'd1811;
  localparam logic [VAL_W-1:0] OUT_MIN_RST          = 16'd0;
  localparam logic [VAL_W-1:0] OUT_MAX_RST          = 16'd1000;
  localparam logic [VAL_W-1:0] DEADBAND_RST         = 16'd5;
  localparam logic [CH_W-1:0]  SAFETY_CHANNEL_RST   = 4'd7;
  localparam logic [VAL_W-1:0] SAFETY_THRESHOLD_RST = 16'd500;

  typedef enum logic [2:0] {
    REG_RAW_MIN          = 3'd0,
    REG_RAW_MAX          = 3'd1,
    REG_OUT_MIN          = 3'd2,
    REG_OUT_MAX          = 3'd3,
    REG_DEADBAND         = 3'd4,
    REG_SAFETY_CHANNEL   = 3'd5,
    REG_SAFETY_THRESHOLD = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_min;
    logic [RAW_W-1:0] raw_max;
    logic [VAL_W-1:0] out_min;
    logic [VAL_W-1:0] out_max;
    logic [VAL_W-1:0] deadband;
    logic [CH_W-1:0]  safety_channel;
    logic [VAL_W-1:0] safety_threshold;
  } cfg_t;

  // classified item handed from the mapping pipeline to the back end
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             fs;
    logic [VAL_W-1:0] mapped;
  } item_t;

  typedef struct packed {
    logic                room;
    logic                nonempty;
    logic [QUEUE_AW:0]   used;
  } qstat_t;

endpackage

### src/rcsd_cfg_regs.sv
// rcsd_cfg_regs: APB-style register file for the mapping and safety settings.
// Depends on rcsd_pkg.
module rcsd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcsd_pkg::CFG_AW-1:0]    paddr,
  input  logic [rcsd_pkg::CFG_DW-1:0]    pwdata,
  output logic [rcsd_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready,
  output rcsd_pkg::cfg_t                 cfg
);

  rcsd_pkg::cfg_t   cfg_r;
  rcsd_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = rcsd_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.raw_min          <= rcsd_pkg::RAW_MIN_RST;
      cfg_r.raw_max          <= rcsd_pkg::RAW_MAX_RST;
      cfg_r.out_min          <= rcsd_pkg::OUT_MIN_RST;
      cfg_r.out_max          <= rcsd_pkg::OUT_MAX_RST;
      cfg_r.deadband         <= rcsd_pkg::DEADBAND_RST;
      cfg_r.safety_channel   <= rcsd_pkg::SAFETY_CHANNEL_RST;
      cfg_r.safety_threshold <= rcsd_pkg::SAFETY_THRESHOLD_RST;
    end else if (wr_en) begin
      case (idx)
        rcsd_pkg::REG_RAW_MIN:          cfg_r.raw_min          <= pwdata[10:0];
        rcsd_pkg::REG_RAW_MAX:          cfg_r.raw_max          <= pwdata[10:0];
        rcsd_pkg::REG_OUT_MIN:          cfg_r.out_min          <= pwdata[15:0];
        rcsd_pkg::REG_OUT_MAX:          cfg_r.out_max          <= pwdata[15:0];
        rcsd_pkg::REG_DEADBAND:         cfg_r.deadband         <= pwdata[15:0];
        rcsd_pkg::REG_SAFETY_CHANNEL:   cfg_r.safety_channel   <= pwdata[3:0];
        rcsd_pkg::REG_SAFETY_THRESHOLD: cfg_r.safety_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rcsd_pkg::REG_RAW_MIN:          prdata = 32'(cfg_r.raw_min);
      rcsd_pkg::REG_RAW_MAX:          prdata = 32'(cfg_r.raw_max);
      rcsd_pkg::REG_OUT_MIN:          prdata = 32'(cfg_r.out_min);
      rcsd_pkg::REG_OUT_MAX:          prdata = 32'(cfg_r.out_max);
      rcsd_pkg::REG_DEADBAND:         prdata = 32'(cfg_r.deadband);
      rcsd_pkg::REG_SAFETY_CHANNEL:   prdata = 32'(cfg_r.safety_channel);
      rcsd_pkg::REG_SAFETY_THRESHOLD: prdata = 32'(cfg_r.safety_threshold);
      default:                        prdata = '0;
    endcase
  end

endmodule

### src/rcsd_front.sv
// rcsd_front: linear range map as a free-running pipeline (subtract, multiply,
// one restoring-division stage per quotient bit, offset and saturate).
// Depends on rcsd_pkg.
module rcsd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_fire,
  input  logic [rcsd_pkg::CH_W-1:0]      in_channel,
  input  logic [rcsd_pkg::RAW_W-1:0]     in_raw_value,
  input  logic                           in_failsafe,
  input  rcsd_pkg::cfg_t                 cfg,
  output logic                           push,
  output rcsd_pkg::item_t                push_item
);

  localparam int DS  = rcsd_pkg::DIV_STAGES;
  localparam int PW  = rcsd_pkg::PROD_W;
  localparam int RW  = rcsd_pkg::RAW_W;
  localparam int VW  = rcsd_pkg::VAL_W;

  typedef struct packed {
    logic [rcsd_pkg::CH_W-1:0] ch;
    logic                      fs;
    logic                      neg;
    logic [RW-1:0]             rem;
    logic [PW-1:0]             nq;    // numerator bits shift out, quotient bits shift in
  } dstage_t;

  // input stage
  logic                       v0_r;
  logic [rcsd_pkg::CH_W-1:0]  ch0_r;
  logic                       fs0_r;
  logic [RW:0]                diff0_r;

  // division pipeline; entry 0 holds the product
  dstage_t    st_r   [0:DS];
  dstage_t    st_nxt [0:DS];
  logic [DS:0] v_r;

  logic [RW:0]   neg_diff;
  logic [RW-1:0] mag_a;
  logic [VW:0]   dout;
  logic [VW:0]   neg_dout;
  logic [VW-1:0] mag_b;
  logic [RW-1:0] divisor;
  logic          span_pos;

  logic [PW:0]   sq;
  logic [PW+1:0] sum;
  logic [VW-1:0] mapped;

  assign divisor  = cfg.raw_max - cfg.raw_min;
  assign span_pos = cfg.raw_max > cfg.raw_min;

  assign neg_diff = -diff0_r;
  assign mag_a    = diff0_r[RW] ? neg_diff[RW-1:0] : diff0_r[RW-1:0];
  assign dout     = {1'b0, cfg.out_max} - {1'b0, cfg.out_min};
  assign neg_dout = -dout;
  assign mag_b    = dout[VW] ? neg_dout[VW-1:0] : dout[VW-1:0];

  always_comb begin
    logic [RW:0] trial;
    logic [RW:0] red;
    logic        ge;
    st_nxt[0].ch  = ch0_r;
    st_nxt[0].fs  = fs0_r;
    st_nxt[0].neg = diff0_r[RW] ^ dout[VW];
    st_nxt[0].rem = '0;
    st_nxt[0].nq  = {{VW{1'b0}}, mag_a} * {{RW{1'b0}}, mag_b};
    for (int k = 0; k < DS; k++) begin
      trial = {st_r[k].rem, st_r[k].nq[PW-1]};
      ge    = trial >= {1'b0, divisor};
      red   = trial - {1'b0, divisor};
      st_nxt[k+1]     = st_r[k];
      st_nxt[k+1].rem = ge ? red[RW-1:0] : trial[RW-1:0];
      st_nxt[k+1].nq  = {st_r[k].nq[PW-2:0], ge};
    end
  end

  // truncating quotient with sign, plus out_min, clamped to 16 bits; out_min alone when raw_max <= raw_min
  always_comb begin
    sq  = st_r[DS].neg ? -{1'b0, st_r[DS].nq} : {1'b0, st_r[DS].nq};
    sum = {sq[PW], sq} + (PW+2)'(cfg.out_min);
    if (!span_pos) begin
      mapped = cfg.out_min;
    end else if (sum[PW+1]) begin
      mapped = '0;
    end else if (sum[PW:VW] != '0) begin
      mapped = '1;
    end else begin
      mapped = sum[VW-1:0];
    end
  end

  assign push             = v_r[DS];
  assign push_item.ch     = st_r[DS].ch;
  assign push_item.fs     = st_r[DS].fs;
  assign push_item.mapped = mapped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v_r  <= '0;
    end else begin
      v0_r <= in_fire;
      v_r  <= {v_r[DS-1:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    ch0_r   <= in_channel;
    fs0_r   <= in_failsafe;
    diff0_r <= {1'b0, in_raw_value} - {1'b0, cfg.raw_min};
    for (int k = 0; k <= DS; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

endmodule

### src/rcsd_queue.sv
// rcsd_queue: item queue between the mapping pipeline and the back end, with a
// credit count that covers items still in the pipeline. Depends on rcsd_pkg.
module rcsd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              reserve,
  input  logic              push,
  input  rcsd_pkg::item_t   push_item,
  input  logic              pop,
  output rcsd_pkg::item_t   head,
  output rcsd_pkg::qstat_t  stat
);

  localparam int AW = rcsd_pkg::QUEUE_AW;
  localparam int DEPTH = rcsd_pkg::QUEUE_DEPTH;

  rcsd_pkg::item_t mem_r [0:DEPTH-1];
  rcsd_pkg::item_t head_r;
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic [AW:0]     used_r, used_nxt;

  assign head          = head_r;
  assign stat.room     = used_r < (AW+1)'(DEPTH);
  assign stat.nonempty = cnt_r != '0;
  assign stat.used     = used_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    // credits: taken at accept, returned when the back end takes the item
    used_nxt   = used_r + (AW+1)'(reserve) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      used_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
    // an entry written this cycle that becomes the head is forwarded
    if (push && wr_ptr_r == rd_ptr_nxt) begin
      head_r <= push_item;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

endmodule

### src/rcsd_back.sv
// rcsd_back: per-channel store, deadband hold, safety flag and output register.
// Depends on rcsd_pkg.
module rcsd_back #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcsd_pkg::cfg_t                cfg,
  input  rcsd_pkg::item_t               head,
  input  logic                          nonempty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcsd_pkg::CH_W-1:0]     out_channel_out,
  output logic [rcsd_pkg::VAL_W-1:0]    out_value,
  output logic                          out_held,
  output logic                          out_safety_off
);

  localparam int IDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int VW   = rcsd_pkg::VAL_W;

  logic [VW-1:0]   store_r [0:NUM_CHANNELS-1];
  logic            safety_r, safety_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [rcsd_pkg::CH_W-1:0] ch_r;
  logic [VW-1:0]   value_r, value_nxt;
  logic            held_r, held_nxt;

  logic [IDXW-1:0] idx;
  logic            in_range;
  logic [VW-1:0]   prev;
  logic signed [VW+1:0] m, p, d;

  assign pop      = nonempty && (!out_valid_r || out_ready);
  assign idx      = IDXW'(head.ch);
  assign in_range = 32'(head.ch) < 32'(NUM_CHANNELS);
  assign prev     = store_r[idx];

  assign m = (VW+2)'(head.mapped);
  assign p = (VW+2)'(prev);
  assign d = (VW+2)'(cfg.deadband);

  always_comb begin
    value_nxt  = '0;
    held_nxt   = 1'b0;
    safety_nxt = safety_r;
    if (in_range) begin
      if (!head.fs) begin
        // inside the open band around the stored value: keep it
        if (m < p + d && m > p - d) begin
          value_nxt = prev;
          held_nxt  = 1'b1;
        end else begin
          value_nxt = head.mapped;
        end
      end
      if (head.ch == cfg.safety_channel) begin
        safety_nxt = value_nxt > cfg.safety_threshold;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      safety_r    <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        safety_r <= safety_nxt;
        if (in_range) begin
          store_r[idx] <= value_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ch_r    <= head.ch;
      value_r <= value_nxt;
      held_r  <= held_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = ch_r;
  assign out_value       = value_r;
  assign out_held        = held_r;
  assign out_safety_off  = safety_r;

endmodule

### src/rc_channel_scale_deadband_core.sv
// rc_channel_scale_deadband_core: top level of the RC channel conditioner.
// Depends on rcsd_pkg, rcsd_cfg_regs, rcsd_front, rcsd_queue, rcsd_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one channel sample per transaction,
//   channel number, 11-bit raw value and failsafe flag.
//   Output channel (out_valid/out_ready): one result per sample, in order:
//   channel, conditioned 16-bit value, deadband-held flag, safety flag.
//   APB-style port (psel..pready): seven 32-bit registers at 4*index,
//   written in the access cycle, pready tied high; write only while idle.
// Path: an accepted sample passes through the 29-stage mapping pipeline
//   (difference, product, one division stage per quotient bit, offset/clamp
//   at its end), then the queue and the output register before out_valid.
// Throughput: one sample per cycle while in_ready is high; the pipeline never
//   stalls; a 32-entry credit-tracked queue holds finished items for the back end.
// Receiver stall: results wait in the output register and queue; in_ready
//   drops once 32 samples are in flight or waiting.
// Reset: rst_n synchronous, active low; clears registers to their defaults,
//   the per-channel store and the safety flag to zero, and empties the queue.
module rc_channel_scale_deadband_core #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rcsd_pkg::CH_W-1:0]      in_channel,
  input  logic [rcsd_pkg::RAW_W-1:0]     in_raw_value,
  input  logic                           in_failsafe,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rcsd_pkg::CH_W-1:0]      out_channel_out,
  output logic [rcsd_pkg::VAL_W-1:0]     out_value,
  output logic                           out_held,
  output logic                           out_safety_off,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcsd_pkg::CFG_AW-1:0]    paddr,
  input  logic [rcsd_pkg::CFG_DW-1:0]    pwdata,
  output logic [rcsd_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);

  rcsd_pkg::cfg_t   cfg;
  rcsd_pkg::item_t  push_item;
  rcsd_pkg::item_t  head;
  rcsd_pkg::qstat_t stat;
  logic             in_fire;
  logic             push;
  logic             pop;

  assign in_ready = stat.room;
  assign in_fire  = in_valid & in_ready;

  rcsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_channel   (in_channel),
    .in_raw_value (in_raw_value),
    .in_failsafe  (in_failsafe),
    .cfg          (cfg),
    .push         (push),
    .push_item    (push_item)
  );

  rcsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (in_fire),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  rcsd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .head            (head),
    .nonempty        (stat.nonempty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel_out (out_channel_out),
    .out_value       (out_value),
    .out_held        (out_held),
    .out_safety_off  (out_safety_off)
  );

  // credits never exceed the queue depth
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.used <= (rcsd_pkg::QUEUE_AW+1)'(rcsd_pkg::QUEUE_DEPTH))
    else $error("credit count above queue depth");

  // an accepted transaction with no pop takes exactly one credit
  a_credit_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !pop) |=> stat.used == $past(stat.used) + 1'b1)
    else $error("credit not taken on accept");

  // an item leaving the pipeline must hold a credit
  a_push_credit: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> stat.used != '0)
    else $error("pipeline item without credit");

endmodule

### sim/tb_rc_channel_scale_deadband_core.sv
// Testbench for rc_channel_scale_deadband_core: directed and random channel samples,
// register settings at the extremes, random idling on both sides and a long output stall.
// Depends on rcsd_pkg and the core RTL; a behavioral predictor checks every result.
`timescale 1ns / 1ps

module tb_rc_channel_scale_deadband_core;

  localparam int NUM_CHANNELS = 16;
  localparam int DRAIN_CYCLES = 40;   // idle time after the last result, beyond the depth of the mapping pipeline
  localparam int RAW_MAX_VAL  = (1 << rcsd_pkg::RAW_W) - 1;
  localparam int VAL_MAX_VAL  = (1 << rcsd_pkg::VAL_W) - 1;

  typedef struct {
    logic [rcsd_pkg::CH_W-1:0]  ch;
    logic [rcsd_pkg::VAL_W-1:0] value;
    logic                       held;
    logic                       safety_off;
  } chan_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [rcsd_pkg::CH_W-1:0]    in_channel;
  logic [rcsd_pkg::RAW_W-1:0]   in_raw_value;
  logic                         in_failsafe;
  logic                         out_valid;
  logic                         out_ready;
  logic [rcsd_pkg::CH_W-1:0]    out_channel_out;
  logic [rcsd_pkg::VAL_W-1:0]   out_value;
  logic                         out_held;
  logic                         out_safety_off;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rcsd_pkg::CFG_AW-1:0]  paddr;
  logic [rcsd_pkg::CFG_DW-1:0]  pwdata;
  logic [rcsd_pkg::CFG_DW-1:0]  prdata;
  logic                         pready;

  // predictor state
  rcsd_pkg::cfg_t               cfg_q;
  logic [rcsd_pkg::VAL_W-1:0]   chan_store [NUM_CHANNELS];
  logic                         safety_q;
  chan_result_t                 pending_results [$];

  int unsigned                  mismatch_count;
  bit                           tx_idle_en;
  bit                           rx_idle_en;
  int unsigned                  rx_hold_req;
  logic [rcsd_pkg::RAW_W-1:0]   last_raw [NUM_CHANNELS];

  rc_channel_scale_deadband_core #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_raw_value    (in_raw_value),
    .in_failsafe     (in_failsafe),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel_out (out_channel_out),
    .out_value       (out_value),
    .out_held        (out_held),
    .out_safety_off  (out_safety_off),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("[rc_channel_scale_deadband_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [rcsd_pkg::VAL_W-1:0] scale_raw(
      input logic [rcsd_pkg::RAW_W-1:0] raw);
    longint span;
    longint num;
    longint r;
    span = longint'(cfg_q.raw_max) - longint'(cfg_q.raw_min);
    if (span <= 0) begin
      r = longint'(cfg_q.out_min);
    end else begin
      num = (longint'(raw) - longint'(cfg_q.raw_min)) *
            (longint'(cfg_q.out_max) - longint'(cfg_q.out_min));
      r = num / span + longint'(cfg_q.out_min);   // truncates toward zero
    end
    if (r < 0) r = 0;
    if (r > VAL_MAX_VAL) r = VAL_MAX_VAL;
    return rcsd_pkg::VAL_W'(r);
  endfunction

  function automatic chan_result_t condition_sample(input logic [rcsd_pkg::CH_W-1:0] ch,
                                                    input logic [rcsd_pkg::RAW_W-1:0] raw,
                                                    input logic fs);
    chan_result_t res;
    longint m;
    longint p;
    longint d;
    res.ch    = ch;
    res.value = '0;
    res.held  = 1'b0;
    if (int'(ch) < NUM_CHANNELS) begin
      if (!fs) begin
        m = longint'(scale_raw(raw));
        p = longint'(chan_store[ch]);
        d = longint'(cfg_q.deadband);
        if (m < p + d && m > p - d) begin
          res.value = chan_store[ch];
          res.held  = 1'b1;
        end else begin
          res.value = rcsd_pkg::VAL_W'(m);
        end
      end
      chan_store[ch] = res.value;
      if (ch == cfg_q.safety_channel) safety_q = (res.value > cfg_q.safety_threshold);
    end
    res.safety_off = safety_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // register writes, accepted samples and returned results, in that order per edge
  always @(posedge clk) begin
    chan_result_t want;
    if (!rst_n) begin
      cfg_q.raw_min          = rcsd_pkg::RAW_MIN_RST;
      cfg_q.raw_max          = rcsd_pkg::RAW_MAX_RST;
      cfg_q.out_min          = rcsd_pkg::OUT_MIN_RST;
      cfg_q.out_max          = rcsd_pkg::OUT_MAX_RST;
      cfg_q.deadband         = rcsd_pkg::DEADBAND_RST;
      cfg_q.safety_channel   = rcsd_pkg::SAFETY_CHANNEL_RST;
      cfg_q.safety_threshold = rcsd_pkg::SAFETY_THRESHOLD_RST;
      foreach (chan_store[i]) chan_store[i] = '0;
      safety_q = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (rcsd_pkg::reg_idx_t'(paddr[rcsd_pkg::CFG_AW-1:2]))
          rcsd_pkg::REG_RAW_MIN:
            cfg_q.raw_min          = pwdata[rcsd_pkg::RAW_W-1:0];
          rcsd_pkg::REG_RAW_MAX:
            cfg_q.raw_max          = pwdata[rcsd_pkg::RAW_W-1:0];
          rcsd_pkg::REG_OUT_MIN:
            cfg_q.out_min          = pwdata[rcsd_pkg::VAL_W-1:0];
          rcsd_pkg::REG_OUT_MAX:
            cfg_q.out_max          = pwdata[rcsd_pkg::VAL_W-1:0];
          rcsd_pkg::REG_DEADBAND:
            cfg_q.deadband         = pwdata[rcsd_pkg::VAL_W-1:0];
          rcsd_pkg::REG_SAFETY_CHANNEL:
            cfg_q.safety_channel   = pwdata[rcsd_pkg::CH_W-1:0];
          rcsd_pkg::REG_SAFETY_THRESHOLD:
            cfg_q.safety_threshold = pwdata[rcsd_pkg::VAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_results.push_back(condition_sample(in_channel, in_raw_value, in_failsafe));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected (channel %0d)",
                   $time, out_channel_out);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_channel_out !== want.ch)
            report_mismatch("channel_out", 32'(want.ch), 32'(out_channel_out));
          if (out_value !== want.value)
            report_mismatch("value", 32'(want.value), 32'(out_value));
          if (out_held !== want.held)
            report_mismatch("held", 32'(want.held), 32'(out_held));
          if (out_safety_off !== want.safety_off)
            report_mismatch("safety_off", 32'(want.safety_off), 32'(out_safety_off));
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // result sink: random stalls, plus long hold-offs on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
      end
      out_ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_sample(input logic [rcsd_pkg::CH_W-1:0] ch,
                             input logic [rcsd_pkg::RAW_W-1:0] raw,
                             input logic fs);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_channel   <= ch;
    in_raw_value <= raw;
    in_failsafe  <= fs;
    last_raw[ch] = raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the predictor record a transaction taken at this edge
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input rcsd_pkg::reg_idx_t idx,
                           input logic [rcsd_pkg::CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setup(input int rmin, input int rmax, input int omin, input int omax,
                             input int db, input int sch, input int thr);
    wait_idle();
    write_reg(rcsd_pkg::REG_RAW_MIN, rmin);
    write_reg(rcsd_pkg::REG_RAW_MAX, rmax);
    write_reg(rcsd_pkg::REG_OUT_MIN, omin);
    write_reg(rcsd_pkg::REG_OUT_MAX, omax);
    write_reg(rcsd_pkg::REG_DEADBAND, db);
    write_reg(rcsd_pkg::REG_SAFETY_CHANNEL, sch);
    write_reg(rcsd_pkg::REG_SAFETY_THRESHOLD, thr);
  endtask

  task automatic apply_random_setup();
    int unsigned kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0: apply_setup($urandom_range(100, 300), $urandom_range(1700, 1900),
                     $urandom_range(0, 1500), $urandom_range(1000, 2500),
                     $urandom_range(0, 20), $urandom_range(0, 15), $urandom_range(0, 2500));
      1: apply_setup($urandom_range(0, 600), $urandom_range(1400, RAW_MAX_VAL),
                     $urandom_range(0, VAL_MAX_VAL), $urandom_range(0, VAL_MAX_VAL),
                     $urandom_range(0, 2000), $urandom_range(0, 15),
                     $urandom_range(0, VAL_MAX_VAL));
      2: apply_setup($urandom_range(0, RAW_MAX_VAL), $urandom_range(0, RAW_MAX_VAL),
                     $urandom_range(0, VAL_MAX_VAL), $urandom_range(0, VAL_MAX_VAL),
                     $urandom_range(0, VAL_MAX_VAL), $urandom_range(0, 15),
                     $urandom_range(0, VAL_MAX_VAL));
      default: apply_setup($urandom_range(0, 1) * RAW_MAX_VAL, $urandom_range(0, 1) * RAW_MAX_VAL,
                           $urandom_range(0, 1) * VAL_MAX_VAL,
                           $urandom_range(0, 1) * VAL_MAX_VAL,
                           $urandom_range(0, 1) * VAL_MAX_VAL, $urandom_range(0, 1) * 15,
                           $urandom_range(0, 1) * VAL_MAX_VAL);
    endcase
  endtask

  // frame-like channel order, raw values often close to the last one for deadband hits
  task automatic send_random_samples(input int unsigned count);
    logic [rcsd_pkg::CH_W-1:0] ch;
    int                        raw;
    int unsigned               r;
    ch = '0;
    repeat (count) begin
      if ($urandom_range(0, 99) < 60) ch = ch + 1'b1;
      else ch = rcsd_pkg::CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      r = $urandom_range(0, 99);
      if (r < 40) raw = int'(last_raw[ch]) + $urandom_range(0, 20) - 10;
      else if (r < 45) raw = $urandom_range(0, 1) * RAW_MAX_VAL;
      else raw = $urandom_range(0, RAW_MAX_VAL);
      if (raw < 0) raw = 0;
      if (raw > RAW_MAX_VAL) raw = RAW_MAX_VAL;
      send_sample(ch, rcsd_pkg::RAW_W'(raw), $urandom_range(0, 99) < 4);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_settings();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_sample(0, 172, 0);
    send_sample(15, 1811, 0);
    send_sample(1, 0, 0);                               // below range, clamps low
    send_sample(2, rcsd_pkg::RAW_W'(RAW_MAX_VAL), 0);   // above range, extrapolates
    send_sample(3, 1000, 0);
    send_sample(3, 1003, 0);         // inside deadband
    send_sample(3, 1020, 0);
    send_sample(3, 1020, 1);         // failsafe zeroes the store
    send_sample(7, 1811, 0);         // safety channel above threshold
    send_sample(7, 1811, 1);         // failsafe on safety channel clears the flag
    send_sample(7, 1100, 0);
    send_sample(6, rcsd_pkg::RAW_W'(RAW_MAX_VAL), 1);
  endtask

  task automatic test_register_extremes();
    // empty raw range maps to out_min
    apply_setup(RAW_MAX_VAL, 0, VAL_MAX_VAL, 0, 0, 0, 0);
    send_sample(0, 5, 0);
    send_sample(9, rcsd_pkg::RAW_W'(RAW_MAX_VAL), 0);
    // falling output range, widest deadband
    apply_setup(0, RAW_MAX_VAL, VAL_MAX_VAL, 0, VAL_MAX_VAL, 15, VAL_MAX_VAL);
    send_sample(0, 0, 0);
    send_sample(15, rcsd_pkg::RAW_W'(RAW_MAX_VAL), 0);
    send_sample(4, 1024, 0);
    // steep slope saturates both ways
    apply_setup(1000, 1001, 0, VAL_MAX_VAL, 1, 5, 1000);
    send_sample(5, rcsd_pkg::RAW_W'(RAW_MAX_VAL), 0);
    send_sample(5, 0, 0);
    send_sample(5, 1001, 0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      apply_random_setup();
      tx_idle_en = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (phase != 0) && ($urandom_range(0, 3) != 0);
      send_random_samples(250);
    end
  endtask

  task automatic test_output_stall();
    apply_setup(172, 1811, 0, 1000, 5, 7, 500);
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 300;   // input side must back up while this runs
    send_random_samples(80);
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    send_random_samples(20);
  endtask

  initial begin
    mismatch_count = 0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_hold_req    = 0;
    foreach (last_raw[i]) last_raw[i] = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_channel   <= '0;
    in_raw_value <= '0;
    in_failsafe  <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_register_extremes();
    test_random_traffic();
    test_output_stall();
    wait_idle();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[rc_channel_scale_deadband_core] OK");
    end else begin
      $display("[rc_channel_scale_deadband_core] ERROR");
    end
    $finish;
  end

endmodule
